// ----- sv/pps_pkg.sv -----
// Package for the pulse pattern sequencer: sizes, field layout and codes.
// Depends on nothing; used by pulse_pattern_sequencer_top.
package pps_pkg;

  // Table depth and step duration width.
  localparam int MAX_STEPS  = 16;
  localparam int DELAY_BITS = 16;

  // Derived widths of the internal state.
  localparam int STEP_W    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int LEN_W     = $clog2(MAX_STEPS + 1);
  localparam int ELAPSED_W = DELAY_BITS + 1;

  // Fixed widths of the item fields.
  localparam int OP_W    = 2;
  localparam int IDX_W   = 4;
  localparam int LEVEL_W = 2;
  localparam int PLEN_W  = 5;

  // Input tdata layout, lowest field first.
  localparam int IDX_LSB   = 0;
  localparam int LEVEL_LSB = IDX_LSB + IDX_W;
  localparam int DELAY_LSB = LEVEL_LSB + LEVEL_W;
  localparam int PLEN_LSB  = DELAY_LSB + DELAY_BITS;
  localparam int REP_LSB   = PLEN_LSB + PLEN_W;
  localparam int IN_BITS   = REP_LSB + 1;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  // Output tdata layout, lowest field first.
  localparam int OUT_BITS   = 2 + IDX_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Item kinds carried on in_tuser.
  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  // Step level codes; any other code leaves the pin as it is.
  localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 2'd1;

endpackage

// ----- sv/pulse_pattern_sequencer_top.sv -----
// Top level of the pulse pattern sequencer: step tables, sequencing state
// and the result register. Depends on pps_pkg.
//
//  channel  dir  ports                         contents
//  in       in   in_tvalid/tready/tdata/tuser  tuser: op; tdata: step fields, length, mode
//  out      out  out_tvalid/tready/tdata       tdata: pin level, active flag, current step
//
// Every item updates the state registers and loads the result register at the
// edge of its transfer, so one item per cycle is taken.
// A result waiting in the output register holds off the next input only while
// out_tready is low; a result taken in the same cycle frees the register.
// Reset clears the sequencing state and the result register valid; the step
// tables are not cleared and must be written before a pattern reads them.
module pulse_pattern_sequencer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [3:0] step_index, [5:4] step_level, [21:6] step_delay,
  // [26:22] pattern_length, [27] repeat_mode, [31:28] zero
  input  logic [pps_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] op
  input  logic [pps_pkg::OP_W-1:0]        in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] pin_level, [1] pattern_active, [5:2] current_step, [7:6] zero
  output logic [pps_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import pps_pkg::*;

  // Step tables, one entry per step.
  logic [LEVEL_W-1:0]    level_tab_r [MAX_STEPS];
  logic [DELAY_BITS-1:0] delay_tab_r [MAX_STEPS];

  // Sequencing state.
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [LEN_W-1:0]     length_r, length_nxt;
  logic                 repeat_r, repeat_nxt;
  logic                 running_r, running_nxt;
  logic                 pin_r, pin_nxt;

  // Result register.
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;

  // Unpacked input fields.
  op_t                   op;
  logic [IDX_W-1:0]      f_index;
  logic [LEVEL_W-1:0]    f_level;
  logic [DELAY_BITS-1:0] f_delay;
  logic [PLEN_W-1:0]     f_length;
  logic                  f_repeat;
  logic                  in_xfer;

  // Helpers for the step change.
  logic [ELAPSED_W-1:0]  elapsed_inc;
  logic [STEP_W-1:0]     step_succ;
  logic [STEP_W-1:0]     level_addr;
  logic [LEVEL_W-1:0]    level_rd;
  logic                  apply_lvl;
  logic                  idx_ok;

  assign op       = op_t'(in_tuser);
  assign f_index  = in_tdata[IDX_LSB +: IDX_W];
  assign f_level  = in_tdata[LEVEL_LSB +: LEVEL_W];
  assign f_delay  = in_tdata[DELAY_LSB +: DELAY_BITS];
  assign f_length = in_tdata[PLEN_LSB +: PLEN_W];
  assign f_repeat = in_tdata[REP_LSB];

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign idx_ok    = 32'(f_index) < 32'(MAX_STEPS);

  // Saturating tick count and the index of the following step.
  assign elapsed_inc = (&elapsed_r) ? elapsed_r : elapsed_r + ELAPSED_W'(1);
  assign step_succ   = step_r + STEP_W'(1);
  assign level_rd    = level_tab_r[level_addr];

  // Next state for the item on the input.
  always_comb begin
    step_nxt    = step_r;
    elapsed_nxt = elapsed_r;
    length_nxt  = length_r;
    repeat_nxt  = repeat_r;
    running_nxt = running_r;
    pin_nxt     = pin_r;
    level_addr  = '0;
    apply_lvl   = 1'b0;
    case (op)
      OP_TICK: begin
        if (running_r) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc > ELAPSED_W'(delay_tab_r[step_r])) begin
            elapsed_nxt = '0;
            if (32'(step_r) + 1 < 32'(length_r)) begin
              step_nxt   = step_succ;
              level_addr = step_succ;
              apply_lvl  = 1'b1;
            end else if (repeat_r) begin
              step_nxt   = '0;
              apply_lvl  = 1'b1;
            end else begin
              running_nxt = 1'b0;
              step_nxt    = '0;
              pin_nxt     = 1'b0;
            end
          end
        end
      end
      OP_WRITE: begin
        // Table writes are done in the clocked block below.
      end
      OP_START: begin
        if (f_length == '0) begin
          length_nxt = LEN_W'(1);
        end else if (32'(f_length) > 32'(MAX_STEPS)) begin
          length_nxt = LEN_W'(MAX_STEPS);
        end else begin
          length_nxt = LEN_W'(f_length);
        end
        repeat_nxt  = f_repeat;
        step_nxt    = '0;
        elapsed_nxt = '0;
        running_nxt = 1'b1;
        apply_lvl   = 1'b1;
      end
      default: begin
        running_nxt = 1'b0;
        step_nxt    = '0;
        elapsed_nxt = '0;
        pin_nxt     = 1'b0;
      end
    endcase
    // Level of the step just entered; other codes keep the pin.
    if (apply_lvl) begin
      if (level_rd == LEVEL_LOW) begin
        pin_nxt = 1'b0;
      end else if (level_rd == LEVEL_HIGH) begin
        pin_nxt = 1'b1;
      end
    end
  end

  // Sequencing state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      elapsed_r   <= '0;
      length_r    <= LEN_W'(1);
      repeat_r    <= 1'b0;
      running_r   <= 1'b0;
      pin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        step_r      <= step_nxt;
        elapsed_r   <= elapsed_nxt;
        length_r    <= length_nxt;
        repeat_r    <= repeat_nxt;
        running_r   <= running_nxt;
        pin_r       <= pin_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; no reset needed.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= OUT_DATA_W'({IDX_W'(step_nxt), running_nxt, pin_nxt});
    end
  end

  // Step table writes.
  always_ff @(posedge clk) begin
    if (in_xfer && op == OP_WRITE && idx_ok) begin
      level_tab_r[STEP_W'(f_index)] <= f_level;
      delay_tab_r[STEP_W'(f_index)] <= f_delay;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A stop leaves the pattern halted with the pin low at step zero.
  a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && op == OP_STOP |=> !running_r && !pin_r && step_r == '0)
    else $error("stop did not halt the pattern");

  // A start runs from a cleared tick count.
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && op == OP_START |=> running_r && elapsed_r == '0 && step_r == '0)
    else $error("start did not begin the pattern");

  // The tick count stays cleared while no pattern runs.
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> elapsed_r == '0)
    else $error("tick count nonzero while stopped");

  // The step in effect is always inside the pattern.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(step_r) < 32'(length_r) && length_r != '0)
    else $error("step outside the pattern length");

endmodule

// ----- test/pps_pin_checker.sv -----
// Checker for the pulse pattern sequencer: watches both stream channels, predicts
// the pin state after every input transfer and compares it with each output transfer.
// Depends on pps_pkg; instantiated by pulse_pattern_sequencer_top_tb.
module pps_pin_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [pps_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [pps_pkg::OP_W-1:0]       in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [pps_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             mismatches,
  output int                             pending
);
  import pps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic             pin;
    logic             active;
    logic [STEP_W-1:0] step;
  } pin_state_t;

  // Shadow copy of the sequencer state.
  logic [LEVEL_W-1:0]    level_tbl [MAX_STEPS];
  logic [DELAY_BITS-1:0] delay_tbl [MAX_STEPS];
  logic [STEP_W-1:0]     step_q;
  logic [ELAPSED_W-1:0]  elapsed_q;
  logic [LEN_W-1:0]      len_q;
  logic                  rep_q;
  logic                  run_q;
  logic                  pin_q;

  pin_state_t expected_pins [$];
  int         err_cnt = 0;

  // Levels other than low and high leave the pin as it is.
  function automatic void apply_step_level();
    if (level_tbl[step_q] == LEVEL_LOW) pin_q = 1'b0;
    else if (level_tbl[step_q] == LEVEL_HIGH) pin_q = 1'b1;
  endfunction

  function automatic void halt_pattern();
    run_q = 1'b0;
    step_q = '0;
    elapsed_q = '0;
    pin_q = 1'b0;
  endfunction

  // Updates the shadow state for one input transfer and returns the pin state after it.
  function automatic pin_state_t next_pin_state(op_t op, logic [IN_DATA_W-1:0] data);
    pin_state_t res;
    logic [IDX_W-1:0] idx;
    int n;
    idx = data[IDX_LSB +: IDX_W];
    case (op)
      OP_TICK: begin
        if (run_q) begin
          if (elapsed_q != {ELAPSED_W{1'b1}}) elapsed_q = elapsed_q + 1'b1;
          // The step ends once the count passes its duration.
          if (elapsed_q > {1'b0, delay_tbl[step_q]}) begin
            elapsed_q = '0;
            if (int'(step_q) + 1 < int'(len_q)) begin
              step_q = step_q + 1'b1;
              apply_step_level();
            end else if (rep_q) begin
              step_q = '0;
              apply_step_level();
            end else begin
              halt_pattern();
            end
          end
        end
      end
      OP_WRITE: begin
        if (int'(idx) < MAX_STEPS) begin
          level_tbl[idx] = data[LEVEL_LSB +: LEVEL_W];
          delay_tbl[idx] = data[DELAY_LSB +: DELAY_BITS];
        end
      end
      OP_START: begin
        // A length of zero runs one step; lengths past the table are clipped.
        n = int'(data[PLEN_LSB +: PLEN_W]);
        if (n == 0) n = 1;
        if (n > MAX_STEPS) n = MAX_STEPS;
        len_q = LEN_W'(n);
        rep_q = data[REP_LSB];
        step_q = '0;
        elapsed_q = '0;
        run_q = 1'b1;
        apply_step_level();
      end
      default: halt_pattern();
    endcase
    res.pin = pin_q;
    res.active = run_q;
    res.step = step_q;
    return res;
  endfunction

  // Results are compared before the new prediction is queued, since an output
  // transfer in the same cycle always belongs to an earlier input.
  always @(posedge clk) begin : track
    pin_state_t want;
    if (!rst_n) begin
      step_q = '0;
      elapsed_q = '0;
      len_q = LEN_W'(1);
      rep_q = 1'b0;
      run_q = 1'b0;
      pin_q = 1'b0;
      expected_pins.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_pins.size() == 0) begin
          $error("output transfer with no prediction pending, tdata %h", out_tdata);
          err_cnt++;
        end else begin
          want = expected_pins.pop_front();
          if (out_tdata[0] !== want.pin) begin
            $error("pin_level mismatch: expected %0d, got %0d", want.pin, out_tdata[0]);
            err_cnt++;
          end
          if (out_tdata[1] !== want.active) begin
            $error("pattern_active mismatch: expected %0d, got %0d",
                   want.active, out_tdata[1]);
            err_cnt++;
          end
          if (out_tdata[2 +: STEP_W] !== want.step) begin
            $error("current_step mismatch: expected %0d, got %0d",
                   want.step, out_tdata[2 +: STEP_W]);
            err_cnt++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_pins.insert(expected_pins.size(),
                             next_pin_state(op_t'(in_tuser), in_tdata));
    end
    pending = expected_pins.size();
    mismatches = err_cnt;
  end

endmodule

// ----- test/pulse_pattern_sequencer_top_tb.sv -----
// Testbench top for the pulse pattern sequencer: clock, reset, stimulus with random
// idling on both channels, a watchdog and the verdict.
// Depends on pps_pkg, pulse_pattern_sequencer_top and pps_pin_checker.
module pulse_pattern_sequencer_top_tb;
  import pps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 400;
  localparam int CALM_ITEMS   = 40;
  localparam int STALL_LIMIT  = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = OP_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  logic calm = 1'b0;
  int   mismatches;
  int   pending;
  int   stall_left = 0;
  int   idle_cycles = 0;

  always #5 clk = ~clk;

  pulse_pattern_sequencer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  pps_pin_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // Result side: random stall bursts, none once the run calms down.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: ends the run after too long without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one item, after an optional idle burst, and returns at the edge of its
  // transfer. Ready is sampled at the falling edge, where it is settled.
  task automatic send_item(input op_t op, input logic [IDX_W-1:0] idx,
                           input logic [LEVEL_W-1:0] lvl,
                           input logic [DELAY_BITS-1:0] dly,
                           input logic [PLEN_W-1:0] plen, input logic rep);
    logic rdy;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= IN_DATA_W'({rep, plen, dly, lvl, idx});
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
  endtask

  // Mostly ticks so that patterns advance, with table writes, starts and stops
  // mixed in. Fields an operation ignores carry random noise.
  task automatic send_random_item();
    int r;
    op_t op;
    logic [DELAY_BITS-1:0] dly;
    logic [PLEN_W-1:0] plen;
    r = $urandom_range(0, 99);
    if (r < 60) op = OP_TICK;
    else if (r < 80) op = OP_WRITE;
    else if (r < 93) op = OP_START;
    else op = OP_STOP;
    dly = DELAY_BITS'($urandom());
    plen = PLEN_W'($urandom());
    // Short durations keep patterns moving; a long one now and then.
    if (op == OP_WRITE && $urandom_range(0, 99) < 92) dly = DELAY_BITS'($urandom_range(0, 4));
    if (op == OP_START && $urandom_range(0, 99) < 80) plen = PLEN_W'($urandom_range(0, 6));
    send_item(op, IDX_W'($urandom()), LEVEL_W'($urandom()), dly, plen,
              1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the whole table first so no pattern reads an unwritten entry. Level
    // codes cycle through low, high, unchanged and the unused code.
    for (int i = 0; i < MAX_STEPS; i++)
      send_item(OP_WRITE, IDX_W'(i), LEVEL_W'(i % 4),
                (i == 0) ? '0 : (i == MAX_STEPS - 1) ? '1 : DELAY_BITS'(i % 3),
                '0, 1'b0);
    // Zero length runs a single step, which ends on its first tick.
    send_item(OP_START, '0, '0, '0, '0, 1'b0);
    send_item(OP_TICK, '0, '0, '0, '0, 1'b0);
    // Tick while stopped changes nothing.
    send_item(OP_TICK, '0, '0, '0, '0, 1'b0);
    // Oversized length is clipped to the table depth.
    send_item(OP_START, '0, '0, '0, '1, 1'b1);
    send_item(OP_TICK, '0, '0, '0, '0, 1'b0);
    // Rewrite a step while the pattern runs.
    send_item(OP_WRITE, IDX_W'(2), LEVEL_HIGH, '0, '0, 1'b0);
    send_item(OP_TICK, '0, '0, '0, '0, 1'b0);
    send_item(OP_TICK, '0, '0, '0, '0, 1'b0);
    // Restart while running, then stop twice.
    send_item(OP_START, '0, '0, '0, PLEN_W'(3), 1'b0);
    send_item(OP_STOP, '0, '0, '0, '0, 1'b0);
    send_item(OP_STOP, '0, '0, '0, '0, 1'b0);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
      send_random_item();
    end
    in_tvalid <= 1'b0;

    // Drain the outstanding results, then give the block a few more cycles.
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
